// File: rtl/core/gprp_pkg.sv
// package for the glyph row pixel profiler
// holds field widths, register indexes, record kinds, sequencer states and shared types
// no dependencies
package gprp_pkg;

  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HEIGHT      = 2'd3;

  localparam logic REC_PIXEL = 1'b0;
  localparam logic REC_EDGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_USE,
    ST_EM_RD,
    ST_EM_USE,
    ST_EDGE
  } seq_state_e;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    logic             data;
  } rs_wr_t;

endpackage

// File: rtl/core/gprp_row_store.sv
// row store of the glyph row pixel profiler: one bit per column
// single write port, one read port with registered data
// depends on gprp_pkg
module gprp_row_store #(
  parameter int unsigned DEPTH = 63
) (
  input  logic                      clk_i,
  input  gprp_pkg::rs_wr_t          wr_i,
  input  logic [gprp_pkg::COL_W-1:0] rd_addr_i,
  output logic                      rd_data_o
);
  import gprp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic mem_q [DEPTH];
  logic rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i[AW-1:0]];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/glyph_row_pixel_profiler.sv
// top level of the glyph row pixel profiler: config registers, counters, scan sequencer
// and output register; depends on gprp_pkg and gprp_row_store
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o | pixel_black_i
//   out     | output    | out_valid_o/out_ready_i | record_kind_o .. last_o (8 fields)
//   cfg     | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// a pixel that does not end a profiled row is only stored; a row above the baseline then starts
// two passes over the row store, a count pass and an emit pass, plus an edge record when its height
// is below the x-height; each pass reads a column, then uses it, bound by the store's single read port
// in_ready_o is low during the passes; a stalled output holds the emit pass on a black pixel
// reset clears counters, sets width 63 and height 255 and clears baseline and x-height; the row store is not cleared
module glyph_row_pixel_profiler #(
  parameter int unsigned MAX_WIDTH  = 63,
  parameter int unsigned MAX_HEIGHT = 255
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gprp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gprp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             pixel_black_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             record_kind_o,
  output logic [gprp_pkg::COL_W-1:0]       pixel_x_o,
  output logic [gprp_pkg::ROW_W-1:0]       height_above_base_o,
  output logic [gprp_pkg::COL_W-1:0]       count_right_o,
  output logic [gprp_pkg::COL_W-1:0]       count_left_o,
  output logic [gprp_pkg::COL_W-1:0]       left_edge_o,
  output logic [gprp_pkg::COL_W-1:0]       right_edge_o,
  output logic                             last_o
);
  import gprp_pkg::*;

  seq_state_e state_q, state_d;

  logic [COL_W-1:0] width_q, w_eff;
  logic [ROW_W-1:0] height_q, h_eff;
  logic [ROW_W-1:0] base_q, xh_q;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] x_q, x_d;
  logic [COL_W-1:0] total_q, total_d;
  logic [COL_W-1:0] left_q, left_d;
  logic [COL_W-1:0] lmost_q, lmost_d;
  logic [COL_W-1:0] rmost_q, rmost_d;
  logic             has_q, has_d;
  logic [ROW_W-1:0] hgt_q, hgt_d;
  logic             edge_q, edge_d;

  logic             out_valid_q;
  logic             rec_kind_q, rec_kind_d;
  logic [COL_W-1:0] rec_x_q, rec_x_d;
  logic [COL_W-1:0] rec_cr_q, rec_cr_d;
  logic [COL_W-1:0] rec_cl_q, rec_cl_d;
  logic [COL_W-1:0] rec_le_q, rec_le_d;
  logic [COL_W-1:0] rec_re_q, rec_re_d;
  logic             rec_last_q, rec_last_d;
  logic             out_load;

  logic             in_fire, slot_free, x_last, rd_bit;
  logic [COL_W-1:0] right_cnt;
  logic [ROW_W:0]   row_inc;
  rs_wr_t           rs_wr;

  // effective geometry
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = COL_W'(1);
    end else if ({1'b0, width_q} > (COL_W+1)'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if ({1'b0, height_q} > (ROW_W+1)'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= COL_W'(63);
      height_q <= ROW_W'(255);
      base_q   <= '0;
      xh_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GLYPH_WIDTH:   width_q  <= cfg_data_i[COL_W-1:0];
        CFG_GLYPH_HEIGHT:  height_q <= cfg_data_i[ROW_W-1:0];
        CFG_BASELINE_ROWS: base_q   <= cfg_data_i[ROW_W-1:0];
        CFG_X_HEIGHT:      xh_q     <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign x_last     = ({1'b0, x_q} + (COL_W+1)'(1)) >= {1'b0, w_eff};
  assign right_cnt  = total_q - left_q - COL_W'(1);
  assign row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);

  always_comb begin
    rs_wr.we   = in_fire && ({1'b0, col_q} < (COL_W+1)'(MAX_WIDTH));
    rs_wr.addr = col_q;
    rs_wr.data = pixel_black_i;
  end

  gprp_row_store #(
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i     (clk_i),
    .wr_i      (rs_wr),
    .rd_addr_i (x_q),
    .rd_data_o (rd_bit)
  );

  // sequencer and datapath next state
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    x_d        = x_q;
    total_d    = total_q;
    left_d     = left_q;
    lmost_d    = lmost_q;
    rmost_d    = rmost_q;
    has_d      = has_q;
    hgt_d      = hgt_q;
    edge_d     = edge_q;
    out_load   = 1'b0;
    rec_kind_d = REC_PIXEL;
    rec_x_d    = x_q;
    rec_cr_d   = right_cnt;
    rec_cl_d   = left_q;
    rec_le_d   = '0;
    rec_re_d   = '0;
    rec_last_d = !edge_q && (right_cnt == '0);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (({1'b0, col_q} + (COL_W+1)'(1)) < {1'b0, w_eff}) begin
            col_d = col_q + COL_W'(1);
          end else begin
            col_d = '0;
            row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
            if (row_q < base_q) begin
              hgt_d   = base_q - row_q - ROW_W'(1);
              edge_d  = (base_q - row_q - ROW_W'(1)) < xh_q;
              x_d     = '0;
              total_d = '0;
              left_d  = '0;
              lmost_d = '1;
              rmost_d = '0;
              has_d   = 1'b0;
              state_d = ST_CNT_RD;
            end
          end
        end
      end
      ST_CNT_RD: begin
        state_d = ST_CNT_USE;
      end
      ST_CNT_USE: begin
        if (rd_bit) begin
          total_d = total_q + COL_W'(1);
          rmost_d = x_q;
          has_d   = 1'b1;
          if (!has_q) begin
            lmost_d = x_q;
          end
        end
        if (x_last) begin
          x_d     = '0;
          state_d = ST_EM_RD;
        end else begin
          x_d     = x_q + COL_W'(1);
          state_d = ST_CNT_RD;
        end
      end
      ST_EM_RD: begin
        state_d = ST_EM_USE;
      end
      ST_EM_USE: begin
        if (!rd_bit || slot_free) begin
          if (rd_bit) begin
            out_load = 1'b1;
            left_d   = left_q + COL_W'(1);
          end
          if (!x_last) begin
            x_d     = x_q + COL_W'(1);
            state_d = ST_EM_RD;
          end else if (edge_q) begin
            state_d = ST_EDGE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EDGE: begin
        rec_kind_d = REC_EDGE;
        rec_x_d    = '0;
        rec_cr_d   = '0;
        rec_cl_d   = '0;
        rec_le_d   = has_q ? lmost_q : w_eff;
        rec_re_d   = has_q ? (w_eff - rmost_q) : w_eff;
        rec_last_d = 1'b1;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      x_q     <= '0;
      total_q <= '0;
      left_q  <= '0;
      lmost_q <= '1;
      rmost_q <= '0;
      has_q   <= 1'b0;
      hgt_q   <= '0;
      edge_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      x_q     <= x_d;
      total_q <= total_d;
      left_q  <= left_d;
      lmost_q <= lmost_d;
      rmost_q <= rmost_d;
      has_q   <= has_d;
      hgt_q   <= hgt_d;
      edge_q  <= edge_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rec_kind_q <= rec_kind_d;
      rec_x_q    <= rec_x_d;
      rec_cr_q   <= rec_cr_d;
      rec_cl_q   <= rec_cl_d;
      rec_le_q   <= rec_le_d;
      rec_re_q   <= rec_re_d;
      rec_last_q <= rec_last_d;
    end
  end

  logic [ROW_W-1:0] rec_h_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rec_h_q <= hgt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign record_kind_o       = rec_kind_q;
  assign pixel_x_o           = rec_x_q;
  assign height_above_base_o = rec_h_q;
  assign count_right_o       = rec_cr_q;
  assign count_left_o        = rec_cl_q;
  assign left_edge_o         = rec_le_q;
  assign right_edge_o        = rec_re_q;
  assign last_o              = rec_last_q;

`ifndef SYNTH
  a_left_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_USE && rd_bit) |-> left_q < total_q)
    else $error("more black pixels emitted than counted");

  a_edge_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o == REC_EDGE) |-> last_o)
    else $error("edge record not marked last");

  a_last_pixel_no_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o == REC_PIXEL && last_o) |-> count_right_o == '0)
    else $error("last pixel record has black pixels to its right");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ({1'b0, col_q} < (COL_W+1)'(MAX_WIDTH)))
    else $error("column counter beyond row store depth");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output register overwritten while held");
`endif

endmodule
